@@ rtl/mwm_pkg.sv @@
package mwm_pkg;

  // Default speed field width (two's complement)
  localparam int unsigned SPEED_WIDTH_DEF = 16;

  // Configuration register file
  localparam int unsigned NUM_REGS  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned REG_RESET = 3500;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ROTATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_LIMIT    = 3'd3;

  // Number of wheels in the mix
  localparam int unsigned NUM_WHEELS = 4;

endpackage

@@ rtl/mwm_cfg_if.sv @@
interface mwm_cfg_if import mwm_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [SPEED_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mwm_cmd_if.sv @@
interface mwm_cmd_if import mwm_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] vx;
  logic signed [SPEED_WIDTH-1:0] vy;
  logic signed [SPEED_WIDTH-1:0] omega;

  modport source (output valid, output vx, output vy, output omega, input ready);
  modport sink   (input valid, input vx, input vy, input omega, output ready);
endinterface

@@ rtl/mwm_wheel_if.sv @@
interface mwm_wheel_if import mwm_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] wheel_speed_0;
  logic signed [SPEED_WIDTH-1:0] wheel_speed_1;
  logic signed [SPEED_WIDTH-1:0] wheel_speed_2;
  logic signed [SPEED_WIDTH-1:0] wheel_speed_3;

  modport source (output valid, output wheel_speed_0, output wheel_speed_1,
                  output wheel_speed_2, output wheel_speed_3, input ready);
  modport sink   (input valid, input wheel_speed_0, input wheel_speed_1,
                  input wheel_speed_2, input wheel_speed_3, output ready);
endinterface

@@ rtl/mwm_div_lane.sv @@
// One wheel lane: pipelined restoring divider, one quotient bit per stage,
// followed by sign restore and bypass select.
module mwm_div_lane import mwm_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*SPEED_WIDTH-1:0] num_i,
  input  logic [SPEED_WIDTH:0]   den_i,
  input  logic                   neg_i,
  input  logic                   scale_i,
  input  logic [SPEED_WIDTH-1:0] byp_i,
  output logic [SPEED_WIDTH-1:0] res_o
);

  localparam int unsigned W  = SPEED_WIDTH;
  localparam int unsigned Q  = W - 1;   // quotient bits, one per stage
  localparam int unsigned AW = 2 * W;   // remainder (W+1) plus quotient (Q)

  logic [AW-1:0] acc_q [Q];
  logic [W:0]    den_q [Q];
  logic          neg_q [Q];
  logic          scl_q [Q];
  logic [W-1:0]  byp_q [Q];

  logic [AW-1:0] acc_d [Q];

  for (genvar j = 0; j < Q; j++) begin : g_stage
    logic [AW-1:0] src_acc;
    logic [W:0]    src_den;
    logic          src_neg;
    logic          src_scl;
    logic [W-1:0]  src_byp;
    logic [W+1:0]  trial;
    logic [W+1:0]  diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign src_acc = num_i;
      assign src_den = den_i;
      assign src_neg = neg_i;
      assign src_scl = scale_i;
      assign src_byp = byp_i;
    end else begin : g_next
      assign src_acc = acc_q[j-1];
      assign src_den = den_q[j-1];
      assign src_neg = neg_q[j-1];
      assign src_scl = scl_q[j-1];
      assign src_byp = byp_q[j-1];
    end

    // Shift in the next numerator bit and try a subtract
    always_comb begin
      trial    = {src_acc[AW-1 -: W+1], src_acc[Q-1]};
      diff     = trial - {1'b0, src_den};
      ge       = (trial >= {1'b0, src_den});
      acc_d[j] = {(ge ? diff[W:0] : trial[W:0]), src_acc[Q-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j] <= acc_d[j];
        den_q[j] <= src_den;
        neg_q[j] <= src_neg;
        scl_q[j] <= src_scl;
        byp_q[j] <= src_byp;
      end
    end
  end

  // Sign restore on the quotient, or pass the unscaled speed
  logic [W-1:0] quot;

  always_comb begin
    quot = {1'b0, acc_q[Q-1][Q-1:0]};
    if (!scl_q[Q-1]) begin
      res_o = byp_q[Q-1];
    end else if (neg_q[Q-1]) begin
      res_o = -quot;
    end else begin
      res_o = quot;
    end
  end

endmodule

@@ rtl/mecanum_wheel_mixer.sv @@
// Channel   Direction  Transfer when         Payload
// cfg_i     in         valid && ready        index, data (register write)
// cmd_i     in         valid && ready        vx, vy, omega
// wheel_o   out        valid && ready        wheel_speed_0 .. wheel_speed_3
//
// One command per cycle while the skid register is empty. Each command passes
// through clamp, mix, max, multiply, then SPEED_WIDTH-1 divider stages (one
// quotient bit each), then the output register.
// Reset clears all valid bits and loads every limit register with 3500.
// A stalled result waits in the output register while one more item lands in
// a skid register; cmd_i.ready drops only while the skid register is full.
module mecanum_wheel_mixer import mwm_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  mwm_cfg_if.sink      cfg_i,
  mwm_cmd_if.sink      cmd_i,
  mwm_wheel_if.source  wheel_o
);

  localparam int unsigned W = SPEED_WIDTH;
  localparam int unsigned Q = W - 1;
  localparam int unsigned P = Q + 4;     // pipeline stages before the output
  localparam logic [W-2:0] LimReset = (W-1)'(REG_RESET);

  // Clamp to [-lim, +lim]
  function automatic logic signed [W-1:0] clamp_f(input logic signed [W-1:0] v,
                                                  input logic [W-2:0] lim);
    logic signed [W:0] ve;
    logic signed [W:0] lp;
    logic signed [W:0] ln;
    ve = (W+1)'(v);
    lp = $signed({2'b00, lim});
    ln = -lp;
    if (ve > lp) begin
      clamp_f = $signed(lp[W-1:0]);
    end else if (ve < ln) begin
      clamp_f = $signed(ln[W-1:0]);
    end else begin
      clamp_f = v;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [W-2:0] limit_x_q, limit_y_q, limit_rot_q, wheel_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_x_q     <= LimReset;
      limit_y_q     <= LimReset;
      limit_rot_q   <= LimReset;
      wheel_limit_q <= LimReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LIMIT_X:        limit_x_q     <= cfg_i.data[W-2:0];
        REG_LIMIT_Y:        limit_y_q     <= cfg_i.data[W-2:0];
        REG_LIMIT_ROTATION: limit_rot_q   <= cfg_i.data[W-2:0];
        REG_WHEEL_LIMIT:    wheel_limit_q <= cfg_i.data[W-2:0];
        default: ;  // writes past the register file are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: whole pipe advances unless the skid register holds an item
  logic         en;
  logic [P-1:0] v_q;
  logic         ov_q, sv_q;
  logic         pop;

  assign en          = !sv_q;
  assign cmd_i.ready = en;
  assign pop         = ov_q && wheel_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[P-2:0], cmd_i.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: clamp
  logic signed [W-1:0] x0_q, y0_q, r0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= clamp_f(cmd_i.vx, limit_x_q);
      y0_q <= clamp_f(cmd_i.vy, limit_y_q);
      r0_q <= clamp_f(cmd_i.omega, limit_rot_q);
    end
  end

  // Stage 1: mix
  logic signed [W+1:0] xe, ye, re;
  logic signed [W+1:0] w1_d [NUM_WHEELS];
  logic signed [W+1:0] w1_q [NUM_WHEELS];

  always_comb begin
    xe      = (W+2)'(x0_q);
    ye      = (W+2)'(y0_q);
    re      = (W+2)'(r0_q);
    w1_d[0] =  xe - ye + re;
    w1_d[1] =  xe + ye + re;
    w1_d[2] = -xe + ye + re;
    w1_d[3] = -xe - ye + re;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q <= w1_d;
    end
  end

  // Stage 2: magnitudes and largest magnitude
  logic [W+1:0]        abs_full [NUM_WHEELS];
  logic [W:0]          mag2_d   [NUM_WHEELS];
  logic [W:0]          max01, max23, max2_d;
  logic [W:0]          mag2_q   [NUM_WHEELS];
  logic [W:0]          max2_q;
  logic signed [W+1:0] w2_q     [NUM_WHEELS];

  always_comb begin
    for (int k = 0; k < NUM_WHEELS; k++) begin
      abs_full[k] = w1_q[k][W+1] ? -w1_q[k] : w1_q[k];
      mag2_d[k]   = abs_full[k][W:0];
    end
    max01  = (mag2_d[0] > mag2_d[1]) ? mag2_d[0] : mag2_d[1];
    max23  = (mag2_d[2] > mag2_d[3]) ? mag2_d[2] : mag2_d[3];
    max2_d = (max01 > max23) ? max01 : max23;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag2_q <= mag2_d;
      max2_q <= max2_d;
      w2_q   <= w1_q;
    end
  end

  // Stage 3: magnitude times wheel limit, scale decision
  logic [2*W-1:0] num3_q [NUM_WHEELS];
  logic [W:0]     den3_q;
  logic           neg3_q [NUM_WHEELS];
  logic [W-1:0]   byp3_q [NUM_WHEELS];
  logic           scl3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
        num3_q[k] <= (2*W)'(mag2_q[k]) * (2*W)'(wheel_limit_q);
        neg3_q[k] <= w2_q[k][W+1];
        byp3_q[k] <= w2_q[k][W-1:0];
      end
      den3_q <= max2_q;
      scl3_q <= (max2_q > {2'b00, wheel_limit_q});
    end
  end

  // Stages 4 .. P-1: per-wheel divider lanes
  logic [W-1:0] res [NUM_WHEELS];

  for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_lane
    mwm_div_lane #(
      .SPEED_WIDTH (SPEED_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .num_i   (num3_q[k]),
      .den_i   (den3_q),
      .neg_i   (neg3_q[k]),
      .scale_i (scl3_q),
      .byp_i   (byp3_q[k]),
      .res_o   (res[k])
    );
  end

  // ---------------------------------------------------------------------
  // Output register with skid register behind it
  logic [W-1:0] o_q [NUM_WHEELS];
  logic [W-1:0] s_q [NUM_WHEELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (pop) begin
        sv_q <= 1'b0;
      end
    end else if (!ov_q || pop) begin
      ov_q <= v_q[P-1];
    end else if (v_q[P-1]) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (pop) begin
        o_q <= s_q;
      end
    end else if (!ov_q || pop) begin
      o_q <= res;
    end else begin
      s_q <= res;
    end
  end

  assign wheel_o.valid         = ov_q;
  assign wheel_o.wheel_speed_0 = o_q[0];
  assign wheel_o.wheel_speed_1 = o_q[1];
  assign wheel_o.wheel_speed_2 = o_q[2];
  assign wheel_o.wheel_speed_3 = o_q[3];

endmodule

@@ dv/mecanum_wheel_mixer_tb.sv @@
`timescale 1ns / 1ps

module mecanum_wheel_mixer_tb;
  import mwm_pkg::*;

  localparam int SW          = SPEED_WIDTH_DEF;
  localparam int LATENCY     = SW + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 200;
  localparam int SPEED_MAX   = 2 ** (SW - 1) - 1;
  localparam int SPEED_MIN   = -(2 ** (SW - 1));
  localparam int LIM_MAX     = 2 ** (SW - 1) - 1;
  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = '1;

  typedef logic signed [SW-1:0] speed_t;
  typedef logic [SW-2:0] limit_t;
  typedef logic [NUM_WHEELS-1:0][SW-1:0] wheels_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [SW-1:0]        val;
    speed_t               vx;
    speed_t               vy;
    speed_t               om;
    logic                 chk;
    wheels_t              want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mwm_cfg_if   #(.SPEED_WIDTH(SW)) cfg ();
  mwm_cmd_if   #(.SPEED_WIDTH(SW)) cmd ();
  mwm_wheel_if #(.SPEED_WIDTH(SW)) wheel ();

  mecanum_wheel_mixer #(.SPEED_WIDTH(SW)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (cmd),
    .wheel_o (wheel)
  );

  // Shadow of the limit registers and the store of wheel sets still owed
  limit_t  limit_reg [NUM_REGS];
  wheels_t pending_wheels [$];
  row_t    dir_rows [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_cnt       = 0;
  int cmd_cnt       = 0;
  int result_cnt    = 0;
  int cfg_cnt       = 0;
  int cycle_cnt     = 0;

  always #1 clk_i = ~clk_i;

  // Symmetric clamp of one command component
  function automatic longint clamp_cmd(speed_t v, limit_t lim);
    longint a;
    longint b;
    a = longint'(v);
    b = longint'(lim);
    if (a > b) return b;
    if (a < -b) return -b;
    return a;
  endfunction

  // Inverse kinematics plus desaturation, from the current register shadow
  function automatic wheels_t wheel_mix(speed_t vx, speed_t vy, speed_t om);
    longint  x, y, r, peak, m, q, s, wl;
    longint  w [NUM_WHEELS];
    wheels_t res;
    x  = clamp_cmd(vx, limit_reg[REG_LIMIT_X]);
    y  = clamp_cmd(vy, limit_reg[REG_LIMIT_Y]);
    r  = clamp_cmd(om, limit_reg[REG_LIMIT_ROTATION]);
    wl = longint'(limit_reg[REG_WHEEL_LIMIT]);
    w[0] = x - y + r;
    w[1] = x + y + r;
    w[2] = -x + y + r;
    w[3] = -x - y + r;
    peak = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      m = (w[i] < 0) ? -w[i] : w[i];
      if (m > peak) peak = m;
    end
    for (int i = 0; i < NUM_WHEELS; i++) begin
      s = w[i];
      if (peak > wl) begin
        m = (w[i] < 0) ? -w[i] : w[i];
        q = (m * wl) / peak;   // truncates toward zero on the magnitude
        s = (w[i] < 0) ? -q : q;
      end
      res[i] = s[SW-1:0];
    end
    return res;
  endfunction

  // Random command component, biased towards the clamp edges
  function automatic speed_t rand_speed(limit_t lim);
    int l;
    int v;
    l = lim;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(128) - 64;
      2: v = ($urandom_range(1) ? l : -l) + $urandom_range(6) - 3;
      3: v = $urandom_range(1) ? SPEED_MAX : SPEED_MIN;
      default: v = $urandom_range(2 * l) - l;
    endcase
    return v[SW-1:0];
  endfunction

  function automatic void add_cmd(int vx, int vy, int om, bit chk = 1'b0,
                                  int w0 = 0, int w1 = 0, int w2 = 0, int w3 = 0);
    row_t r;
    r      = '0;
    r.kind = ROW_CMD;
    r.vx   = vx[SW-1:0];
    r.vy   = vy[SW-1:0];
    r.om   = om[SW-1:0];
    r.chk  = chk;
    r.want[0] = w0[SW-1:0];
    r.want[1] = w1[SW-1:0];
    r.want[2] = w2[SW-1:0];
    r.want[3] = w3[SW-1:0];
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [SW-1:0] val);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    dir_rows.push_back(r);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid left high, so the next call may keep it up.
  task automatic cmd_send(speed_t vx, speed_t vy, speed_t om,
                          logic chk, wheels_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd.valid <= 1'b1;
    cmd.vx    <= vx;
    cmd.vy    <= vy;
    cmd.omega <= om;
    do @(posedge clk_i); while (!cmd.ready);
    pending_wheels.push_back(chk ? want : wheel_mix(vx, vy, om));
    cmd_cnt++;
    @(negedge clk_i);
  endtask

  // Hold commands back until every owed result has been seen
  task automatic drain_results();
    cmd.valid <= 1'b0;
    do @(negedge clk_i); while (pending_wheels.size() != 0);
  endtask

  // Register write; only issued once the datapath has drained
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    if (idx < NUM_REGS) limit_reg[idx] = val[SW-2:0];
    cfg_cnt++;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_idle(int snd, int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    wheel.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: each transfer against the oldest owed wheel set
  always @(posedge clk_i) begin
    wheels_t want;
    wheels_t got;
    if (rst_ni && wheel.valid && wheel.ready) begin
      got[0] = wheel.wheel_speed_0;
      got[1] = wheel.wheel_speed_1;
      got[2] = wheel.wheel_speed_2;
      got[3] = wheel.wheel_speed_3;
      result_cnt++;
      if (pending_wheels.size() == 0) begin
        $display("%0t: unexpected wheel result, expected none, got %0d %0d %0d %0d",
                 $time, $signed(got[0]), $signed(got[1]), $signed(got[2]),
                 $signed(got[3]));
        err_cnt++;
      end else begin
        want = pending_wheels.pop_front();
        for (int i = 0; i < NUM_WHEELS; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: wheel_speed_%0d expected %0d, got %0d",
                     $time, i, $signed(want[i]), $signed(got[i]));
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results owed", $time, pending_wheels.size());
      $display("mecanum_wheel_mixer: mismatch");
      $finish;
    end
  end

  initial begin
    logic [SW-1:0] set_val [NUM_REGS];
    int mode;

    rst_ni      = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    cmd.valid   = 1'b0;
    cmd.vx      = '0;
    cmd.vy      = '0;
    cmd.omega   = '0;
    for (int i = 0; i < NUM_REGS; i++) limit_reg[i] = limit_t'(REG_RESET);

    // Directed table; typed results assume the reset limits of 3500
    add_cmd(0, 0, 0, 1, 0, 0, 0, 0);
    add_cmd(SPEED_MAX, 0, 0, 1, 3500, 3500, -3500, -3500);
    add_cmd(SPEED_MIN, 0, 0, 1, -3500, -3500, 3500, 3500);
    add_cmd(0, SPEED_MAX, 0, 1, -3500, 3500, 3500, -3500);
    add_cmd(0, SPEED_MIN, 0, 1, 3500, -3500, -3500, 3500);
    add_cmd(0, 0, SPEED_MAX, 1, 3500, 3500, 3500, 3500);
    add_cmd(0, 0, SPEED_MIN, 1, -3500, -3500, -3500, -3500);
    add_cmd(SPEED_MAX, SPEED_MAX, SPEED_MAX, 1, 1166, 3500, 1166, -1166);
    add_cmd(SPEED_MIN, SPEED_MIN, SPEED_MIN, 1, -1166, -3500, -1166, 1166);
    add_cmd(1000, -200, 300);
    add_cmd(3000, 2000, -1000);
    // top bit of the write is dropped, leaving an x limit of zero
    add_cfg(REG_LIMIT_X, 16'h8000);
    add_cmd(SPEED_MAX, 100, 0, 1, -100, 100, 100, -100);
    // zero wheel limit squashes every non-zero mix
    add_cfg(REG_WHEEL_LIMIT, 16'h0000);
    add_cmd(5, 7, 9, 1, 0, 0, 0, 0);
    add_cmd(0, 0, 0, 1, 0, 0, 0, 0);
    // writes to unmapped indexes must not land anywhere
    add_cfg(IDX_UNMAPPED_LO, 16'h0123);
    add_cfg(IDX_UNMAPPED_HI, 16'hFFFF);
    add_cmd(-5, 3, 1, 1, 0, 0, 0, 0);
    // widest limits
    add_cfg(REG_LIMIT_X, 16'hFFFF);
    add_cfg(REG_LIMIT_Y, 16'hFFFF);
    add_cfg(REG_LIMIT_ROTATION, 16'hFFFF);
    add_cfg(REG_WHEEL_LIMIT, 16'hFFFF);
    add_cmd(SPEED_MAX, SPEED_MAX, SPEED_MAX);
    add_cmd(SPEED_MIN, SPEED_MIN, SPEED_MIN);
    add_cmd(SPEED_MIN, SPEED_MAX, SPEED_MIN);
    // narrowest non-zero limits
    add_cfg(REG_LIMIT_X, 16'h0001);
    add_cfg(REG_LIMIT_Y, 16'h0001);
    add_cfg(REG_LIMIT_ROTATION, 16'h0001);
    add_cfg(REG_WHEEL_LIMIT, 16'h0001);
    add_cmd(SPEED_MAX, SPEED_MIN, SPEED_MAX);
    add_cmd(1, 0, 0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idle(20, 47);
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        drain_results();
        cfg_write(dir_rows[k].idx, dir_rows[k].val);
      end else begin
        cmd_send(dir_rows[k].vx, dir_rows[k].vy, dir_rows[k].om,
                 dir_rows[k].chk, dir_rows[k].want);
      end
    end

    // Random phases, each with its own limit setting, under three idling patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = (ph < 3) ? 0 : (ph < 5) ? 1 : 2;
      case (mode)
        0:       set_idle(20, 47);
        1:       set_idle(47, 20);
        default: set_idle(0, 0);
      endcase
      case (ph)
        0: for (int i = 0; i < NUM_REGS; i++) set_val[i] = SW'(REG_RESET);
        1: for (int i = 0; i < NUM_REGS; i++) set_val[i] = '1;
        2: begin
          for (int i = 0; i < NUM_REGS; i++) set_val[i] = SW'($urandom_range(LIM_MAX));
          set_val[REG_WHEEL_LIMIT] = SW'(1);
        end
        3: begin
          for (int i = 0; i < NUM_REGS; i++) set_val[i] = SW'($urandom_range(LIM_MAX));
          set_val[REG_LIMIT_X]     = '0;
          set_val[REG_WHEEL_LIMIT] = '0;
        end
        default: for (int i = 0; i < NUM_REGS; i++) set_val[i] = SW'($urandom);
      endcase
      drain_results();
      cfg_write(REG_LIMIT_X, set_val[REG_LIMIT_X]);
      cfg_write(REG_LIMIT_Y, set_val[REG_LIMIT_Y]);
      cfg_write(REG_LIMIT_ROTATION, set_val[REG_LIMIT_ROTATION]);
      cfg_write(REG_WHEEL_LIMIT, set_val[REG_WHEEL_LIMIT]);
      cfg_write(CFG_IDX_W'($urandom_range(IDX_UNMAPPED_HI, IDX_UNMAPPED_LO)),
                SW'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd_send(rand_speed(limit_reg[REG_LIMIT_X]),
                 rand_speed(limit_reg[REG_LIMIT_Y]),
                 rand_speed(limit_reg[REG_LIMIT_ROTATION]), 1'b0, '0);
      end
    end

    // Let the pipe empty, then watch for stray results
    drain_results();
    repeat (2 * LATENCY) @(negedge clk_i);

    $display("run covered %0d commands and %0d register writes over %0d limit settings",
             cmd_cnt, cfg_cnt, NUM_PHASES + 5);
    $display("%0d wheel sets checked, %0d owed at the end, %0d field errors",
             result_cnt, pending_wheels.size(), err_cnt);
    if (err_cnt == 0 && pending_wheels.size() == 0) begin
      $display("mecanum_wheel_mixer: match");
    end else begin
      $display("mecanum_wheel_mixer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mwm_pkg.sv
rtl/mwm_cfg_if.sv
rtl/mwm_cmd_if.sv
rtl/mwm_wheel_if.sv
rtl/mwm_div_lane.sv
rtl/mecanum_wheel_mixer.sv
dv/mecanum_wheel_mixer_tb.sv
